// ----- hdl/indexed_list_engine_core_defines.svh -----
// Assertion macros shared by the indexed list engine modules.
`ifndef INDEXED_LIST_ENGINE_CORE_DEFINES_SVH
`define INDEXED_LIST_ENGINE_CORE_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define ILE_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define ILE_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hdl/ile_pkg.sv -----
// Types and constants of the indexed list engine.
`timescale 1ns / 1ps
package ile_pkg;

  // Default store geometry
  localparam int ILE_DEPTH       = 64;
  localparam int ILE_DATA_WIDTH  = 32;
  localparam int ILE_QUEUE_DEPTH = 2;

  // Fixed port field widths
  localparam int ILE_CMD_W    = 3;
  localparam int ILE_POS_W    = 6;
  localparam int ILE_WORD_W   = 32;
  localparam int ILE_STATUS_W = 3;
  localparam int ILE_COUNT_W  = 7;

  typedef enum logic [ILE_CMD_W-1:0] {
    CMD_APPEND  = 3'd0,
    CMD_REPLACE = 3'd1,
    CMD_REMOVE  = 3'd2,
    CMD_READ    = 3'd3,
    CMD_CLEAR   = 3'd4
  } cmd_t;

  typedef enum logic [ILE_STATUS_W-1:0] {
    ST_OK        = 3'd0,
    ST_FULL      = 3'd1,
    ST_EMPTY     = 3'd2,
    ST_NULL      = 3'd3,
    ST_BAD_INDEX = 3'd4
  } status_t;

  // Work left for the back end once a command is classified
  typedef enum logic [1:0] {
    OP_NONE   = 2'd0,
    OP_WRITE  = 2'd1,
    OP_READ   = 2'd2,
    OP_REMOVE = 2'd3
  } op_kind_t;

  typedef struct packed {
    op_kind_t kind;
    status_t  status;
  } ile_ctl_t;

  typedef enum logic [1:0] {
    BK_IDLE  = 2'd0,
    BK_READ  = 2'd1,
    BK_SHIFT = 2'd2
  } back_state_t;

endpackage

// ----- hdl/ile_if.sv -----
// Request and response channel interfaces of the indexed list engine.
`timescale 1ns / 1ps
interface ile_req_if import ile_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [ILE_CMD_W-1:0]  command;
  logic [ILE_POS_W-1:0]  position;
  logic [ILE_WORD_W-1:0] data_value;

  modport source (output valid, output command, output position, output data_value,
                  input ready);
  modport sink (input valid, input command, input position, input data_value,
                output ready);
endinterface

interface ile_rsp_if import ile_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic [ILE_STATUS_W-1:0] status;
  logic [ILE_WORD_W-1:0]   data_out;
  logic [ILE_COUNT_W-1:0]  element_count;
  logic                    is_empty;

  modport source (output valid, output status, output data_out, output element_count,
                  output is_empty, input ready);
  modport sink (input valid, input status, input data_out, input element_count,
                input is_empty, output ready);
endinterface

// ----- hdl/indexed_list_engine_core.sv -----
// Top level of the indexed list engine: front end, command queue and back end.
//
//  channel    dir  handshake      payload
//  request    in   valid / ready  command, position, data_value
//  response   out  valid / ready  status, data_out, element_count, is_empty
//
// The front end takes one command a cycle while the two-entry queue has room.
// In the back end, append, replace, clear and rejected commands finish in BK_IDLE;
// read goes on to BK_READ; remove goes on to BK_READ and, if entries lie above the
// position, to BK_SHIFT, the single store read port walking the tail down one entry per cycle.
// rst is synchronous: it clears the count, the queue and the back end; the store keeps
// its contents and needs no clearing pass. A stalled response holds the back end,
// the queue fills, and request.ready drops.
`timescale 1ns / 1ps
module indexed_list_engine_core import ile_pkg::*; #(
  parameter int DEPTH      = ILE_DEPTH,
  parameter int DATA_WIDTH = ILE_DATA_WIDTH
) (
  input  logic      clk,
  input  logic      rst,
  ile_req_if.sink   request,
  ile_rsp_if.source response
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam int QW = $bits(ile_ctl_t) + AW + DATA_WIDTH + CW;

  logic                  push;
  logic                  q_full;
  logic                  q_empty;
  logic                  q_pop;
  ile_ctl_t              f_ctl;
  logic [AW-1:0]         f_addr;
  logic [DATA_WIDTH-1:0] f_word;
  logic [CW-1:0]         f_count;
  logic [QW-1:0]         q_din;
  logic [QW-1:0]         q_dout;
  ile_ctl_t              b_ctl;
  logic [AW-1:0]         b_addr;
  logic [DATA_WIDTH-1:0] b_word;
  logic [CW-1:0]         b_count;

  ile_front #(
    .DEPTH      (DEPTH),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_front (
    .clk         (clk),
    .rst         (rst),
    .request     (request),
    .q_full      (q_full),
    .push        (push),
    .ctl         (f_ctl),
    .addr        (f_addr),
    .word        (f_word),
    .count_after (f_count)
  );

  // Pack and unpack the queue entry
  assign q_din = {f_ctl, f_addr, f_word, f_count};
  assign {b_ctl, b_addr, b_word, b_count} = q_dout;

  ile_queue #(
    .DEPTH (ILE_QUEUE_DEPTH),
    .WIDTH (QW)
  ) u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .din   (q_din),
    .pop   (q_pop),
    .dout  (q_dout),
    .full  (q_full),
    .empty (q_empty)
  );

  ile_back #(
    .DEPTH      (DEPTH),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .q_valid     (!q_empty),
    .q_pop       (q_pop),
    .ctl         (b_ctl),
    .addr        (b_addr),
    .word        (b_word),
    .count_after (b_count),
    .response    (response)
  );

endmodule

// ----- hdl/ile_front.sv -----
// Front end: accepts commands, tracks the element count and classifies each command.
`timescale 1ns / 1ps
module ile_front import ile_pkg::*; #(
  parameter int DEPTH      = ILE_DEPTH,
  parameter int DATA_WIDTH = ILE_DATA_WIDTH,
  localparam int AW        = $clog2(DEPTH),
  localparam int CW        = $clog2(DEPTH + 1)
) (
  input  logic                  clk,
  input  logic                  rst,
  ile_req_if.sink               request,
  input  logic                  q_full,
  output logic                  push,
  output ile_ctl_t              ctl,
  output logic [AW-1:0]         addr,
  output logic [DATA_WIDTH-1:0] word,
  output logic [CW-1:0]         count_after
);

  localparam int CMPW = (CW > ILE_POS_W) ? CW : ILE_POS_W;

  logic [CW-1:0] count;
  logic [CW-1:0] count_next;
  logic          in_range;

  // Take a transaction whenever the queue has room
  assign request.ready = !q_full;
  assign push          = request.valid && !q_full;

  // Classify the command against the current count
  always_comb begin
    word        = DATA_WIDTH'(request.data_value);
    addr        = AW'(request.position);
    in_range    = CMPW'(request.position) < CMPW'(count);
    ctl.kind    = OP_NONE;
    ctl.status  = ST_OK;
    count_next  = count;
    case (request.command)
      CMD_APPEND: begin
        if (word == '0) begin
          ctl.status = ST_NULL;
        end else if (count == CW'(DEPTH)) begin
          ctl.status = ST_FULL;
        end else begin
          ctl.kind   = OP_WRITE;
          addr       = AW'(count);
          count_next = count + CW'(1);
        end
      end
      CMD_REPLACE: begin
        if (count == '0) begin
          ctl.status = ST_EMPTY;
        end else if (!in_range) begin
          ctl.status = ST_BAD_INDEX;
        end else begin
          ctl.kind = OP_WRITE;
        end
      end
      CMD_REMOVE: begin
        if (!in_range) begin
          ctl.status = ST_BAD_INDEX;
        end else begin
          ctl.kind   = OP_REMOVE;
          count_next = count - CW'(1);
        end
      end
      CMD_READ: begin
        if (!in_range) begin
          ctl.status = ST_BAD_INDEX;
        end else begin
          ctl.kind = OP_READ;
        end
      end
      CMD_CLEAR: begin
        count_next = '0;
      end
      default: begin
      end
    endcase
    count_after = count_next;
  end

  // Advance the count on each accepted transaction
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (push) begin
      count <= count_next;
    end
  end

endmodule

// ----- hdl/ile_queue.sv -----
// Short queue between the front and back ends.
`timescale 1ns / 1ps
`include "indexed_list_engine_core_defines.svh"
module ile_queue #(
  parameter int DEPTH = 2,
  parameter int WIDTH = 8
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] din,
  input  logic             pop,
  output logic [WIDTH-1:0] dout,
  output logic             full,
  output logic             empty
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int FW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] slots [DEPTH];
  logic [PW-1:0]    wr_ptr;
  logic [PW-1:0]    rd_ptr;
  logic [FW-1:0]    fill;

  assign full  = (fill == FW'(DEPTH));
  assign empty = (fill == '0);
  assign dout  = slots[rd_ptr];

  // Store the pushed entry
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= din;
    end
  end

  // Advance pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + PW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + PW'(1);
      end
      if (push && !pop) begin
        fill <= fill + FW'(1);
      end else if (pop && !push) begin
        fill <= fill - FW'(1);
      end
    end
  end

  `ILE_ASSERT_NOW(a_no_push_full, clk, rst, push, fill < FW'(DEPTH), "push into full queue")
  `ILE_ASSERT_NOW(a_no_pop_empty, clk, rst, pop, fill != '0, "pop from empty queue")
  `ILE_ASSERT_NEXT(a_fill_rise, clk, rst, push && !pop, fill == $past(fill) + FW'(1), "fill lost")

endmodule

// ----- hdl/ile_back.sv -----
// Back end: carries out store writes, reads and compacting removals, and registers results.
`timescale 1ns / 1ps
`include "indexed_list_engine_core_defines.svh"
module ile_back import ile_pkg::*; #(
  parameter int DEPTH      = ILE_DEPTH,
  parameter int DATA_WIDTH = ILE_DATA_WIDTH,
  localparam int AW        = $clog2(DEPTH),
  localparam int CW        = $clog2(DEPTH + 1)
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  q_valid,
  output logic                  q_pop,
  input  ile_ctl_t              ctl,
  input  logic [AW-1:0]         addr,
  input  logic [DATA_WIDTH-1:0] word,
  input  logic [CW-1:0]         count_after,
  ile_rsp_if.source             response
);

  logic [DATA_WIDTH-1:0] mem [DEPTH];

  back_state_t           state;
  back_state_t           state_next;

  // Memory port controls
  logic                  wr_en;
  logic [AW-1:0]         wr_addr;
  logic [DATA_WIDTH-1:0] wr_data;
  logic                  rd_en;
  logic [AW-1:0]         rd_addr;
  logic [DATA_WIDTH-1:0] rd_data;

  // Command in flight
  logic                  op_remove;
  logic [CW-1:0]         op_count;
  logic [AW-1:0]         k;
  logic [AW-1:0]         k_next;
  logic [DATA_WIDTH-1:0] held_word;
  logic                  capture;

  // Result register
  logic                  rsp_valid;
  status_t               rsp_status;
  logic [DATA_WIDTH-1:0] rsp_data;
  logic [CW-1:0]         rsp_count;
  logic                  rsp_load;
  status_t               load_status;
  logic [DATA_WIDTH-1:0] load_data;
  logic [CW-1:0]         load_count;
  logic                  slot_free;

  assign slot_free = !rsp_valid || response.ready;

  // Store: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= BK_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Sequence each command; a removal walks the tail down one entry a cycle
  always_comb begin
    state_next  = state;
    q_pop       = 1'b0;
    wr_en       = 1'b0;
    wr_addr     = addr;
    wr_data     = word;
    rd_en       = 1'b0;
    rd_addr     = addr;
    k_next      = k;
    capture     = 1'b0;
    rsp_load    = 1'b0;
    load_status = ST_OK;
    load_data   = '0;
    load_count  = op_count;
    case (state)
      BK_IDLE: begin
        if (q_valid && slot_free) begin
          q_pop       = 1'b1;
          load_status = ctl.status;
          load_count  = count_after;
          k_next      = addr;
          case (ctl.kind)
            OP_WRITE: begin
              wr_en    = 1'b1;
              rsp_load = 1'b1;
            end
            OP_READ, OP_REMOVE: begin
              rd_en      = 1'b1;
              state_next = BK_READ;
            end
            default: begin
              rsp_load = 1'b1;
            end
          endcase
        end
      end
      BK_READ: begin
        capture = 1'b1;
        if (op_remove && (CW'(k) < op_count)) begin
          rd_en      = 1'b1;
          rd_addr    = k + AW'(1);
          state_next = BK_SHIFT;
        end else begin
          rsp_load   = 1'b1;
          load_data  = rd_data;
          state_next = BK_IDLE;
        end
      end
      BK_SHIFT: begin
        wr_en   = 1'b1;
        wr_addr = k;
        wr_data = rd_data;
        k_next  = k + AW'(1);
        if (CW'(k) + CW'(1) < op_count) begin
          rd_en   = 1'b1;
          rd_addr = k + AW'(1) + AW'(1);
        end else begin
          rsp_load   = 1'b1;
          load_data  = held_word;
          state_next = BK_IDLE;
        end
      end
      default: begin
        state_next = BK_IDLE;
      end
    endcase
  end

  // Hold the command in flight
  always_ff @(posedge clk) begin
    k <= k_next;
    if (q_pop) begin
      op_remove <= (ctl.kind == OP_REMOVE);
      op_count  <= count_after;
    end
    if (capture) begin
      held_word <= rd_data;
    end
  end

  // Result register: load when free, drop once taken
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (rsp_load) begin
      rsp_valid <= 1'b1;
    end else if (response.ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rsp_load) begin
      rsp_status <= load_status;
      rsp_data   <= load_data;
      rsp_count  <= load_count;
    end
  end

  assign response.valid         = rsp_valid;
  assign response.status        = rsp_status;
  assign response.data_out      = ILE_WORD_W'(rsp_data);
  assign response.element_count = ILE_COUNT_W'(rsp_count);
  assign response.is_empty      = (rsp_count == '0);

  `ILE_ASSERT_NOW(a_pop_idle, clk, rst, q_pop, state == BK_IDLE, "pop outside idle")
  `ILE_ASSERT_NOW(a_shift_range, clk, rst, state == BK_SHIFT, CW'(k) < op_count, "shift overrun")
  `ILE_ASSERT_NOW(a_load_free, clk, rst, rsp_load, slot_free, "result overwritten")

endmodule
